// ===== src/rtpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpp_pkg
// Shared constants and types of the RGB threshold raster print packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpp_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int COLOR_W    = 8;
   localparam int BYTE_W     = 8;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRAY_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_SPACING   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FEED_LINES     = 3'd4;

   localparam int                WIDTH_RESET     = 400;
   localparam int                HEIGHT_RESET    = 1;
   localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd128;
   localparam logic [BYTE_W-1:0] SPACING_RESET   = 8'd24;
   localparam logic [BYTE_W-1:0] FEED_RESET      = 8'd5;

   // luma weights, scaled by LUMA_SCALE
   localparam int LUMA_W = 18;
   localparam logic [9:0] LUMA_R     = 10'd299;
   localparam logic [9:0] LUMA_G     = 10'd587;
   localparam logic [9:0] LUMA_B     = 10'd114;
   localparam logic [9:0] LUMA_SCALE = 10'd1000;

   // printer command bytes
   localparam logic [BYTE_W-1:0] CMD_ESC     = 8'h1B;
   localparam logic [BYTE_W-1:0] CMD_INIT    = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_SPACING = 8'h33;
   localparam logic [BYTE_W-1:0] CMD_GS      = 8'h1D;
   localparam logic [BYTE_W-1:0] CMD_RASTER  = 8'h76;
   localparam logic [BYTE_W-1:0] CMD_RAS_FN  = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_RAS_MD  = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_FEED    = 8'h64;

   // positions in the byte run of one pixel
   localparam int SEQ_W = 5;
   localparam logic [SEQ_W-1:0] SEQ_INIT_0    = 5'd0;
   localparam logic [SEQ_W-1:0] SEQ_INIT_1    = 5'd1;
   localparam logic [SEQ_W-1:0] SEQ_SPC_0     = 5'd2;
   localparam logic [SEQ_W-1:0] SEQ_SPC_1     = 5'd3;
   localparam logic [SEQ_W-1:0] SEQ_SPC_ARG   = 5'd4;
   localparam logic [SEQ_W-1:0] SEQ_HDR_0     = 5'd5;
   localparam logic [SEQ_W-1:0] SEQ_HDR_1     = 5'd6;
   localparam logic [SEQ_W-1:0] SEQ_HDR_2     = 5'd7;
   localparam logic [SEQ_W-1:0] SEQ_HDR_3     = 5'd8;
   localparam logic [SEQ_W-1:0] SEQ_BPL_LO    = 5'd9;
   localparam logic [SEQ_W-1:0] SEQ_BPL_HI    = 5'd10;
   localparam logic [SEQ_W-1:0] SEQ_HGT_LO    = 5'd11;
   localparam logic [SEQ_W-1:0] SEQ_HGT_HI    = 5'd12;
   localparam logic [SEQ_W-1:0] SEQ_DOT       = 5'd13;
   localparam logic [SEQ_W-1:0] SEQ_FEED_0    = 5'd14;
   localparam logic [SEQ_W-1:0] SEQ_FEED_1    = 5'd15;
   localparam logic [SEQ_W-1:0] SEQ_FEED_ARG  = 5'd16;

   localparam logic KIND_CMD = 1'b0;
   localparam logic KIND_DOT = 1'b1;

   typedef struct packed {
      logic              pre;
      logic              dot;
      logic [BYTE_W-1:0] dot_byte;
      logic              feed;
   } rtpp_event_type;

endpackage

`default_nettype wire

// ===== src/rtpp_req_if.sv =====
// ----------------------------------------------------------------------------
// rtpp_req_if
// Pixel input channel: valid/ready with one RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpp_req_if;
   import rtpp_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_red;
   logic [COLOR_W-1:0] pixel_green;
   logic [COLOR_W-1:0] pixel_blue;

   modport source (output valid, output pixel_red, output pixel_green,
                   output pixel_blue, input ready);
   modport sink   (input valid, input pixel_red, input pixel_green,
                   input pixel_blue, output ready);
endinterface

`default_nettype wire

// ===== src/rtpp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rtpp_rsp_if
// Byte output channel: valid/ready with one printer stream byte and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpp_rsp_if;
   import rtpp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_kind;
   logic              last_of_run;
   logic              job_done;

   modport source (output valid, output out_byte, output byte_kind,
                   output last_of_run, output job_done, input ready);
   modport sink   (input valid, input out_byte, input byte_kind,
                   input last_of_run, input job_done, output ready);
endinterface

`default_nettype wire

// ===== src/rtpp_csr_if.sv =====
// ----------------------------------------------------------------------------
// rtpp_csr_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpp_csr_if;
   import rtpp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] reg_data;

   modport source (output valid, output reg_index, output reg_data, input ready);
   modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ===== src/rtpp_dot_core.sv =====
// ----------------------------------------------------------------------------
// rtpp_dot_core
// Luma threshold, dot packing and row/job position tracking for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpp_dot_core #(
   parameter int COORD_WIDTH = rtpp_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic [rtpp_pkg::COLOR_W-1:0]   red,
   input  wire logic [rtpp_pkg::COLOR_W-1:0]   green,
   input  wire logic [rtpp_pkg::COLOR_W-1:0]   blue,
   input  wire logic [rtpp_pkg::BYTE_W-1:0]    threshold,
   input  wire logic [COORD_WIDTH-1:0]         width,
   input  wire logic [COORD_WIDTH-1:0]         height,
   output      rtpp_pkg::rtpp_event_type       ev,
   output      logic                           ev_empty
);
   import rtpp_pkg::*;

   logic [COORD_WIDTH-1:0] col_ff, col_in;
   logic [COORD_WIDTH-1:0] row_ff, row_in;
   logic [BYTE_W-1:0]      acc_ff, acc_in;
   logic                   started_ff, started_in;

   logic                   start;
   logic [COORD_WIDTH-1:0] col_base, col_inc, row_base, row_inc;
   logic [BYTE_W-1:0]      acc_base, acc_set;
   logic [LUMA_W-1:0]      luma_sum, thr_scaled;
   logic                   dark, row_end, dot_emit, job_end;

   // luma < thr  <=>  weighted sum < thr * scale
   assign luma_sum   = LUMA_W'(red) * LUMA_W'(LUMA_R) + LUMA_W'(green) * LUMA_W'(LUMA_G)
                     + LUMA_W'(blue) * LUMA_W'(LUMA_B);
   assign thr_scaled = LUMA_W'(threshold) * LUMA_W'(LUMA_SCALE);
   assign dark       = luma_sum < thr_scaled;

   always_comb begin
      start    = !started_ff;
      col_base = start ? '0 : col_ff;
      row_base = start ? '0 : row_ff;
      acc_base = start ? '0 : acc_ff;
      acc_set  = acc_base | (dark ? (8'h80 >> col_base[2:0]) : 8'h00);
      col_inc  = col_base + 1'b1;
      row_end  = col_inc == width;
      dot_emit = (col_inc[2:0] == 3'd0) || row_end;
      row_inc  = row_base + 1'b1;
      job_end  = row_end && (row_inc == height);

      col_in     = row_end ? '0 : col_inc;
      row_in     = row_end ? (job_end ? '0 : row_inc) : row_base;
      acc_in     = dot_emit ? '0 : acc_set;
      started_in = !job_end;

      ev.pre      = start;
      ev.dot      = dot_emit;
      ev.dot_byte = acc_set;
      ev.feed     = job_end;
      ev_empty    = !start && !dot_emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         acc_ff     <= '0;
         started_ff <= 1'b0;
      end else if (fire) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         acc_ff     <= acc_in;
         started_ff <= started_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rgb_threshold_raster_print_packer.sv =====
// ----------------------------------------------------------------------------
// rgb_threshold_raster_print_packer
// Packs RGB pixels into a 1-bit raster printer byte stream with preamble and
// closing feed command.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  req_chan  in   pixel_red, pixel_green, pixel_blue
//  rsp_chan  out  out_byte, byte_kind, last_of_run, job_done
//  csr_chan  in   reg_index, reg_data
//
//  One pixel per cycle while rsp is ready and each pixel yields at most one byte.
//  The first pixel of a job also emits the preamble, the last of a job the
//  feed command; the output register moves one byte per cycle while rsp is ready.
//  Path: input register -> luma/pack logic -> byte sequencer -> output reg.
//  Reset clears positions and valids; registers return to their defaults.
//  rsp stalls back up through the sequencer; csr is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_threshold_raster_print_packer #(
   parameter int COORD_WIDTH = rtpp_pkg::COORD_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rtpp_req_if.sink   req_chan,
   rtpp_rsp_if.source rsp_chan,
   rtpp_csr_if.sink   csr_chan
);
   import rtpp_pkg::*;

   localparam int WSUM_W = COORD_WIDTH + 17;
   localparam int HEXT_W = COORD_WIDTH + 16;

   // configuration
   logic [COORD_WIDTH-1:0] width_ff, height_ff;
   logic [BYTE_W-1:0]      thr_ff, spacing_ff, feed_ff;
   logic [HEXT_W-1:0]      csr_ext;
   logic                   csr_wr;

   assign csr_chan.ready = 1'b1;
   assign csr_wr  = csr_chan.valid && csr_chan.ready;
   assign csr_ext = {{COORD_WIDTH{1'b0}}, csr_chan.reg_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= COORD_WIDTH'(WIDTH_RESET);
         height_ff  <= COORD_WIDTH'(HEIGHT_RESET);
         thr_ff     <= THRESHOLD_RESET;
         spacing_ff <= SPACING_RESET;
         feed_ff    <= FEED_RESET;
      end else if (csr_wr) begin
         case (csr_chan.reg_index)
            REG_IMAGE_WIDTH:    width_ff   <= csr_ext[COORD_WIDTH-1:0];
            REG_IMAGE_HEIGHT:   height_ff  <= csr_ext[COORD_WIDTH-1:0];
            REG_GRAY_THRESHOLD: thr_ff     <= csr_chan.reg_data[BYTE_W-1:0];
            REG_LINE_SPACING:   spacing_ff <= csr_chan.reg_data[BYTE_W-1:0];
            REG_FEED_LINES:     feed_ff    <= csr_chan.reg_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic               in_valid_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic               consume, req_xfer;

   rtpp_event_type ev;
   logic           ev_empty;

   // byte sequencer and output register
   logic              em_valid_ff;
   logic [SEQ_W-1:0]  em_idx_ff;
   logic              em_dot_ff, em_feed_ff;
   logic [BYTE_W-1:0] em_byte_ff;
   logic              out_load, em_take, em_last, nxt_valid;
   logic [SEQ_W-1:0]  nxt_idx;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_done_ff, rsp_done_in;

   logic [WSUM_W-1:0] wsum;
   logic [HEXT_W-1:0] hext;

   assign out_load = !rsp_valid_ff || rsp_chan.ready;
   assign em_last  = !nxt_valid;
   assign em_take  = !em_valid_ff || (out_load && em_last);
   assign consume  = in_valid_ff && (ev_empty || em_take);
   assign req_chan.ready = !in_valid_ff || consume;
   assign req_xfer = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         red_ff   <= req_chan.pixel_red;
         green_ff <= req_chan.pixel_green;
         blue_ff  <= req_chan.pixel_blue;
      end
   end

   rtpp_dot_core #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dot_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (consume),
      .red       (red_ff),
      .green     (green_ff),
      .blue      (blue_ff),
      .threshold (thr_ff),
      .width     (width_ff),
      .height    (height_ff),
      .ev        (ev),
      .ev_empty  (ev_empty)
   );

   assign wsum = {17'd0, width_ff} + WSUM_W'(7);
   assign hext = {16'd0, height_ff};

   always_comb begin
      nxt_valid = 1'b1;
      nxt_idx   = em_idx_ff + 1'b1;
      case (em_idx_ff)
         SEQ_HGT_HI: begin
            nxt_valid = em_dot_ff;
            nxt_idx   = SEQ_DOT;
         end
         SEQ_DOT:      nxt_valid = em_feed_ff;
         SEQ_FEED_ARG: nxt_valid = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      rsp_kind_in = KIND_CMD;
      rsp_done_in = 1'b0;
      case (em_idx_ff)
         SEQ_INIT_0:   rsp_byte_in = CMD_ESC;
         SEQ_INIT_1:   rsp_byte_in = CMD_INIT;
         SEQ_SPC_0:    rsp_byte_in = CMD_ESC;
         SEQ_SPC_1:    rsp_byte_in = CMD_SPACING;
         SEQ_SPC_ARG:  rsp_byte_in = spacing_ff;
         SEQ_HDR_0:    rsp_byte_in = CMD_GS;
         SEQ_HDR_1:    rsp_byte_in = CMD_RASTER;
         SEQ_HDR_2:    rsp_byte_in = CMD_RAS_FN;
         SEQ_HDR_3:    rsp_byte_in = CMD_RAS_MD;
         SEQ_BPL_LO:   rsp_byte_in = wsum[10:3];
         SEQ_BPL_HI:   rsp_byte_in = wsum[18:11];
         SEQ_HGT_LO:   rsp_byte_in = hext[7:0];
         SEQ_HGT_HI:   rsp_byte_in = hext[15:8];
         SEQ_DOT: begin
            rsp_byte_in = em_byte_ff;
            rsp_kind_in = KIND_DOT;
         end
         SEQ_FEED_0:   rsp_byte_in = CMD_ESC;
         SEQ_FEED_1:   rsp_byte_in = CMD_FEED;
         SEQ_FEED_ARG: begin
            rsp_byte_in = feed_ff;
            rsp_done_in = 1'b1;
         end
         default:      rsp_byte_in = CMD_RAS_MD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
      end else if (consume && !ev_empty) begin
         em_valid_ff <= 1'b1;
      end else if (em_valid_ff && out_load) begin
         em_valid_ff <= nxt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && !ev_empty) begin
         em_idx_ff  <= ev.pre ? SEQ_INIT_0 : SEQ_DOT;
         em_dot_ff  <= ev.dot;
         em_byte_ff <= ev.dot_byte;
         em_feed_ff <= ev.feed;
      end else if (em_valid_ff && out_load) begin
         em_idx_ff  <= nxt_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= em_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= em_last;
         rsp_done_ff <= rsp_done_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_byte_ff;
   assign rsp_chan.byte_kind   = rsp_kind_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;
   assign rsp_chan.job_done    = rsp_done_ff;

   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff |-> (em_idx_ff <= SEQ_FEED_ARG))
      else $error("sequencer index out of range");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_last_ff && rsp_kind_ff == KIND_CMD))
      else $error("job end byte not last of its run");

   a_seq_hold: assert property (@(posedge clock) disable iff (reset)
      (em_valid_ff && !out_load) |=> (em_valid_ff && $stable(em_idx_ff)))
      else $error("sequencer moved while output stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (consume && !ev_empty) |-> em_take)
      else $error("pixel run loaded over a busy sequencer");

endmodule

`default_nettype wire
